@@ rtl/rpts_pkg.sv @@
package rpts_pkg;

  localparam int NUM_PRIOS_DEF = 32;
  localparam int OP_W          = 2;
  localparam int PRIO_W        = 5;
  localparam int TICKS_W       = 16;
  localparam int MASK_W        = 32;
  localparam int STATUS_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_DELAY  = 2'd1,
    OP_TICK   = 2'd2,
    OP_SCHED  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EXISTS = 2'd1,
    ST_IRQ    = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  typedef struct packed {
    logic create;
    logic load;
    logic tick;
  } cell_cmd_t;

endpackage

@@ rtl/rtos_priority_task_scheduler.sv @@
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | op, task_prio, delay_ticks, in_interrupt
// out     | output    | out_valid / out_ready | ready_mask, highest_ready, switch_request, status
//
// An item is taken only when the scanner is idle. The operation updates the cells at the
// accept edge, then a token walks the cell chain one cell per cycle to find the first ready
// priority; the scan result is registered when the token stops and is then loaded into the
// output register once it is free. Synchronous reset initialises the control state and cells.
// A result waiting in the output register does not block the next accept; a finished scan
// holds until the output register frees.
module rtos_priority_task_scheduler import rpts_pkg::*; #(
  parameter int NUM_PRIOS = NUM_PRIOS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [PRIO_W-1:0]   task_prio,
  input  logic [TICKS_W-1:0]  delay_ticks,
  input  logic                in_interrupt,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [MASK_W-1:0]   ready_mask,
  output logic [PRIO_W-1:0]   highest_ready,
  output logic                switch_request,
  output logic [STATUS_W-1:0] status
);

  localparam int PW = $clog2(NUM_PRIOS);
  localparam logic [PW-1:0] IDLE_PRIO = PW'(NUM_PRIOS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;

  logic [NUM_PRIOS-1:0] ready_vec;
  logic [NUM_PRIOS-1:0] exists_vec;
  logic [NUM_PRIOS-1:0] hit_vec;
  logic [NUM_PRIOS-1:0] sel_prio;
  logic [NUM_PRIOS-1:0] sel_cur;
  logic [NUM_PRIOS:0]   tok_chain;
  cell_cmd_t            cmd [NUM_PRIOS];

  logic [PW-1:0] cur_prio;
  logic [PW-1:0] cnt;
  logic [PW-1:0] res_hi;
  logic          res_sw;
  logic          do_sched;
  status_t       status_q;

  logic    acc;
  logic    create_fail;
  logic    delay_eff;
  logic    hit_any;
  logic    out_free;
  status_t status_next;
  logic [PW+PRIO_W-1:0]     hi_ext;
  logic [NUM_PRIOS+MASK_W-1:0] mask_ext;

  assign in_ready  = (state == S_IDLE);
  assign acc       = in_valid & in_ready;
  assign out_free  = ~out_valid | out_ready;
  assign hit_any   = |hit_vec;

  assign create_fail = ~(|sel_prio) | (|(sel_prio & exists_vec));
  assign delay_eff   = (op_t'(op) == OP_DELAY) & ~in_interrupt &
                       (delay_ticks != '0) & (cur_prio != IDLE_PRIO);

  always_comb begin
    case (op_t'(op))
      OP_CREATE: status_next = create_fail ? ST_EXISTS : ST_OK;
      OP_DELAY:  status_next = in_interrupt ? ST_IRQ : ST_OK;
      OP_TICK:   status_next = ST_OK;
      OP_SCHED:  status_next = in_interrupt ? ST_IRQ : ST_OK;
      default:   status_next = ST_OK;
    endcase
  end

  assign tok_chain[0] = acc;

  for (genvar i = 0; i < NUM_PRIOS; i++) begin : g_cell
    assign sel_prio[i]   = (32'(task_prio) == 32'(i));
    assign sel_cur[i]    = (cur_prio == PW'(i));
    assign cmd[i].create = acc & (op_t'(op) == OP_CREATE) & ~create_fail & sel_prio[i];
    assign cmd[i].load   = acc & delay_eff & sel_cur[i];
    assign cmd[i].tick   = acc & (op_t'(op) == OP_TICK);

    rpts_cell #(
      .IS_IDLE (i == NUM_PRIOS - 1)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd[i]),
      .ticks   (delay_ticks),
      .tok_in  (tok_chain[i]),
      .tok_out (tok_chain[i+1]),
      .hit     (hit_vec[i]),
      .ready   (ready_vec[i]),
      .exists  (exists_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cur_prio <= IDLE_PRIO;
      cnt      <= '0;
      do_sched <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            cnt      <= '0;
            do_sched <= ((op_t'(op) == OP_SCHED) & ~in_interrupt) | delay_eff;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit_any || cnt == IDLE_PRIO) begin
            if (do_sched && cnt != cur_prio) begin
              cur_prio <= cnt;
            end
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_q <= status_next;
    end
    if (state == S_SCAN && (hit_any || cnt == IDLE_PRIO)) begin
      res_hi <= cnt;
      res_sw <= do_sched & (cnt != cur_prio);
    end
  end

  assign hi_ext   = {{PRIO_W{1'b0}}, res_hi};
  assign mask_ext = {{MASK_W{1'b0}}, ready_vec};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      ready_mask     <= mask_ext[MASK_W-1:0];
      highest_ready  <= hi_ext[PRIO_W-1:0];
      switch_request <= res_sw;
      status         <= status_q;
    end
  end

  a_token_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one cell holds the scan token");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    ready_vec[NUM_PRIOS-1] && exists_vec[NUM_PRIOS-1])
    else $error("idle priority lost its ready or exists bit");

  a_ready_exists: assert property (@(posedge clk) disable iff (rst)
    (ready_vec & ~exists_vec) == '0)
    else $error("ready bit set for a priority that does not exist");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result presented without a finished scan");

  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && switch_request |-> status == ST_OK)
    else $error("switch requested with a non-ok status");

endmodule

@@ rtl/rpts_cell.sv @@
module rpts_cell import rpts_pkg::*; #(
  parameter bit IS_IDLE = 1'b0
) (
  input  logic               clk,
  input  logic               rst,
  input  cell_cmd_t          cmd,
  input  logic [TICKS_W-1:0] ticks,
  input  logic               tok_in,
  output logic               tok_out,
  output logic               hit,
  output logic               ready,
  output logic               exists
);

  logic [TICKS_W-1:0] count;
  logic               tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      ready  <= IS_IDLE;
      exists <= IS_IDLE;
      count  <= '0;
      tok    <= 1'b0;
    end else begin
      tok <= tok_in;
      if (cmd.create) begin
        exists <= 1'b1;
        ready  <= 1'b1;
        count  <= '0;
      end else if (cmd.load) begin
        ready <= 1'b0;
        count <= ticks;
      end else if (cmd.tick && count != '0) begin
        count <= count - 1'b1;
        if (count == TICKS_W'(1)) begin
          ready <= 1'b1;
        end
      end
    end
  end

  // token stops at the first ready cell
  assign hit     = tok & ready;
  assign tok_out = tok & ~ready;

endmodule

@@ dv/tb_rtos_priority_task_scheduler.sv @@
`timescale 1ns / 100ps
module tb_rtos_priority_task_scheduler;
  import rpts_pkg::*;

  localparam int                CYCLE_LIMIT = 200000;
  localparam int                DRAIN       = NUM_PRIOS_DEF + 8;
  localparam logic [PRIO_W-1:0] IDLE_PRIO   = PRIO_W'(NUM_PRIOS_DEF - 1);

  typedef struct {
    logic [MASK_W-1:0] mask;
    logic [PRIO_W-1:0] top;
    logic              sw;
    status_t           st;
  } sched_result_t;

  class ready_map_tracker;
    logic [MASK_W-1:0]  ready_bits;
    logic [MASK_W-1:0]  exists_bits;
    logic [TICKS_W-1:0] delay_left [NUM_PRIOS_DEF];
    logic [PRIO_W-1:0]  running;
    sched_result_t      pending_results [$];
    int                 mismatches;

    function new();
      ready_bits  = '0;
      exists_bits = '0;
      ready_bits[IDLE_PRIO]  = 1'b1;
      exists_bits[IDLE_PRIO] = 1'b1;
      foreach (delay_left[p]) delay_left[p] = '0;
      running    = IDLE_PRIO;
      mismatches = 0;
    endfunction

    function logic [PRIO_W-1:0] first_ready();
      for (int p = 0; p < NUM_PRIOS_DEF; p++) begin
        if (ready_bits[p]) return PRIO_W'(p);
      end
      return IDLE_PRIO;
    endfunction

    function logic dispatch();
      logic [PRIO_W-1:0] top;
      top = first_ready();
      if (top != running) begin
        running = top;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // apply one accepted item and queue the result it should produce
    function void take_op(op_t kind, logic [PRIO_W-1:0] prio, logic [TICKS_W-1:0] ticks,
                          logic irq);
      sched_result_t r;
      r.sw = 1'b0;
      r.st = ST_OK;
      case (kind)
        OP_CREATE: begin
          if (exists_bits[prio]) begin
            r.st = ST_EXISTS;
          end else begin
            exists_bits[prio] = 1'b1;
            ready_bits[prio]  = 1'b1;
            delay_left[prio]  = '0;
          end
        end
        OP_DELAY: begin
          if (irq) begin
            r.st = ST_IRQ;
          end else if (ticks != '0 && running != IDLE_PRIO) begin
            ready_bits[running] = 1'b0;
            delay_left[running] = ticks;
            r.sw = dispatch();
          end
        end
        OP_TICK: begin
          for (int p = 0; p < NUM_PRIOS_DEF - 1; p++) begin
            if (delay_left[p] != '0) begin
              delay_left[p] = delay_left[p] - 1'b1;
              if (delay_left[p] == '0) ready_bits[p] = 1'b1;
            end
          end
        end
        default: begin
          if (irq) r.st = ST_IRQ;
          else r.sw = dispatch();
        end
      endcase
      r.mask = ready_bits;
      r.top  = first_ready();
      pending_results.push_back(r);
    endfunction

    function void match_result(logic [MASK_W-1:0] mask, logic [PRIO_W-1:0] top, logic sw,
                               logic [STATUS_W-1:0] st);
      sched_result_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: mask=%h top=%0d sw=%0b st=%0d", mask, top, sw, st);
        return;
      end
      e = pending_results.pop_front();
      if (mask !== e.mask || top !== e.top || sw !== e.sw || st !== e.st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp mask=%h top=%0d sw=%0b st=%0d got mask=%h top=%0d sw=%0b st=%0d",
                   e.mask, e.top, e.sw, e.st, mask, top, sw, st);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     op;
  logic [PRIO_W-1:0]   task_prio;
  logic [TICKS_W-1:0]  delay_ticks;
  logic                in_interrupt;
  logic                out_valid;
  logic                out_ready;
  logic [MASK_W-1:0]   ready_mask;
  logic [PRIO_W-1:0]   highest_ready;
  logic                switch_request;
  logic [STATUS_W-1:0] status;

  ready_map_tracker tracker;
  int               in_gap_max;
  int               out_gap_max;
  int               cycle_count;

  rtos_priority_task_scheduler i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .task_prio      (task_prio),
    .delay_ticks    (delay_ticks),
    .in_interrupt   (in_interrupt),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ready_mask     (ready_mask),
    .highest_ready  (highest_ready),
    .switch_request (switch_request),
    .status         (status)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL rtos_priority_task_scheduler");
    $finish;
  end

  task automatic push_item(op_t kind, logic [PRIO_W-1:0] prio, logic [TICKS_W-1:0] ticks,
                           logic irq);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= kind;
    task_prio    <= prio;
    delay_ticks  <= ticks;
    in_interrupt <= irq;
    do @(posedge clk); while (!(in_valid === 1'b1 && in_ready === 1'b1));
    tracker.take_op(kind, prio, ticks, irq);
  endtask

  // result side
  initial begin
    int gap;
    int taken;
    taken = 0;
    out_gap_max = 5;
    wait (rst === 1'b0);
    forever begin
      if (taken % 40 == 0) out_gap_max = $urandom_range(0, 1) ? 5 : 0;
      gap = $urandom_range(0, out_gap_max);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready === 1'b1));
      tracker.match_result(ready_mask, highest_ready, switch_request, status);
      taken++;
    end
  end

  initial begin
    int               roll;
    op_t              kind;
    logic [TICKS_W-1:0] ticks;
    logic             irq;

    tracker      = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = OP_CREATE;
    task_prio    = '0;
    delay_ticks  = '0;
    in_interrupt = 1'b0;
    out_ready    = 1'b0;
    in_gap_max   = 5;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    push_item(OP_SCHED,  5'd0,  16'd0,      1'b0);
    push_item(OP_CREATE, 5'd31, 16'd0,      1'b0);  // idle always exists
    push_item(OP_CREATE, 5'd0,  16'd0,      1'b0);
    push_item(OP_CREATE, 5'd0,  16'd0,      1'b0);  // duplicate
    push_item(OP_CREATE, 5'd30, 16'd0,      1'b0);
    push_item(OP_CREATE, 5'd5,  16'd0,      1'b0);
    push_item(OP_CREATE, 5'd16, 16'd0,      1'b0);
    push_item(OP_CREATE, 5'd15, 16'd0,      1'b1);
    push_item(OP_SCHED,  5'd0,  16'd0,      1'b1);  // no switch inside interrupt
    push_item(OP_SCHED,  5'd0,  16'd0,      1'b0);
    push_item(OP_DELAY,  5'd0,  16'd3,      1'b1);
    push_item(OP_DELAY,  5'd0,  16'd0,      1'b0);  // zero ticks
    push_item(OP_DELAY,  5'd0,  16'd2,      1'b0);
    push_item(OP_DELAY,  5'd0,  16'hFFFF,   1'b0);
    push_item(OP_DELAY,  5'd0,  16'd1,      1'b0);
    push_item(OP_DELAY,  5'd0,  16'd3,      1'b0);
    push_item(OP_DELAY,  5'd0,  16'd4,      1'b0);
    push_item(OP_DELAY,  5'd0,  16'd7,      1'b0);  // idle task cannot be delayed
    push_item(OP_TICK,   5'd0,  16'd0,      1'b1);
    push_item(OP_TICK,   5'd0,  16'd0,      1'b0);
    push_item(OP_SCHED,  5'd0,  16'd0,      1'b1);
    push_item(OP_SCHED,  5'd0,  16'd0,      1'b0);
    push_item(OP_SCHED,  5'd0,  16'd0,      1'b0);
    push_item(OP_TICK,   5'd31, 16'hFFFF,   1'b1);

    for (int n = 0; n < 650; n++) begin
      if (n % 40 == 0) in_gap_max = $urandom_range(0, 1) ? 5 : 0;
      roll = $urandom_range(0, 99);
      if (roll < 15) kind = OP_CREATE;
      else if (roll < 40) kind = OP_DELAY;
      else if (roll < 75) kind = OP_TICK;
      else kind = OP_SCHED;
      roll = $urandom_range(0, 99);
      if (roll < 5) ticks = '0;
      else if (roll < 9) ticks = TICKS_W'($urandom_range(0, 65535));
      else ticks = TICKS_W'($urandom_range(1, 6));
      irq = ($urandom_range(0, 7) == 0);
      push_item(kind, PRIO_W'($urandom_range(0, 31)), ticks, irq);
    end
    in_valid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("PASS rtos_priority_task_scheduler");
    end else begin
      $display("FAIL rtos_priority_task_scheduler");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rpts_pkg.sv
rtl/rpts_cell.sv
rtl/rtos_priority_task_scheduler.sv
dv/tb_rtos_priority_task_scheduler.sv
